@@ hdl/round_robin_wait_time_calc_core_defines.svh @@
// Assertion macros shared by the round-robin wait time calculator.
`ifndef ROUND_ROBIN_WAIT_TIME_CALC_CORE_DEFINES_SVH
`define ROUND_ROBIN_WAIT_TIME_CALC_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define RRWT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrwt assertion failed");

// The consequent holds in the cycle after the antecedent.
`define RRWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrwt assertion failed");

`endif

@@ hdl/rrwt_pkg.sv @@
// Package with the constants, state type and divider status type of the calculator.
package rrwt_pkg;

   localparam int MaxProcs   = 32;
   localparam int AddrW      = $clog2(MaxProcs);
   localparam int BurstW     = 16;
   localparam int QuantW     = 16;
   localparam int TimeW      = 21;
   localparam int TotalW     = 26;
   localparam int IndexW     = 5;
   localparam int CapW       = 17;
   localparam int DivCntW    = $clog2(BurstW);
   localparam int RspFieldsW = IndexW + 2 * TimeW + 2 * TotalW;
   localparam int RspDataW   = ((RspFieldsW + 7) / 8) * 8;

   localparam logic [QuantW-1:0] QuantumReset = QuantW'(2);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_I,
      ST_CHK_I,
      ST_DIV_WAIT,
      ST_CAP,
      ST_RD_J,
      ST_ACC_J,
      ST_WR_F,
      ST_RD_E,
      ST_LD_E
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ hdl/round_robin_wait_time_calc_core.sv @@
// Top level of the round-robin waiting and turnaround time calculator.
//
//   Port group  Direction  Contents
//   req_        in         burst_time in tdata, last_process in tlast
//   rsp_        out        index, waiting, turnaround and totals in tdata, last row in tlast
//   csr_        in         quantum write, no read-back
//
// Loading accepts one transfer per cycle; req_tready is high only while loading.
// For a process with a nonzero burst the service pass runs the remainder divider on its burst
// and then reads the burst memory once per process of the batch.
// A process with a zero burst skips both and goes from the burst check to writing its finish.
// Each row is read in ST_RD_E and loaded in ST_LD_E, as both memories have registered reads.
// A stalled rsp_ side holds the output register; the next batch loads while the last row waits.
// Reset is synchronous and clears the control state and sets the quantum to 2.
`include "round_robin_wait_time_calc_core_defines.svh"

module round_robin_wait_time_calc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rrwt_pkg::BurstW-1:0]    req_tdata,   // burst_time
   input  logic                           req_tlast,   // last_process
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // process_index, waiting_time, turnaround_time, total_waiting, total_turnaround, zero pad
   output logic [rrwt_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                           rsp_tlast,   // last_result
   input  logic                           csr_wr_en,
   input  logic [rrwt_pkg::QuantW-1:0]    csr_wr_data  // quantum
);

   rrwt_pkg::state_type           state_ff, state_in;
   logic [rrwt_pkg::QuantW-1:0]   quantum_ff, quantum_in;
   logic [rrwt_pkg::QuantW-1:0]   q_eff;
   logic [rrwt_pkg::AddrW-1:0]    cnt_ff, cnt_in;
   logic [rrwt_pkg::AddrW-1:0]    last_idx_ff, last_idx_in;
   logic [rrwt_pkg::AddrW-1:0]    idx_ff, idx_in;
   logic [rrwt_pkg::AddrW-1:0]    jdx_ff, jdx_in;
   logic [rrwt_pkg::BurstW-1:0]   bi_ff, bi_in;
   logic [rrwt_pkg::TimeW-1:0]    t_ff, t_in;
   logic [rrwt_pkg::CapW-1:0]     cap_a_ff, cap_a_in;
   logic [rrwt_pkg::CapW-1:0]     cap_b_ff, cap_b_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [rrwt_pkg::IndexW-1:0]   rsp_index_ff, rsp_index_in;
   logic [rrwt_pkg::TimeW-1:0]    rsp_wt_ff, rsp_wt_in;
   logic [rrwt_pkg::TimeW-1:0]    rsp_tat_ff, rsp_tat_in;
   logic [rrwt_pkg::TotalW-1:0]   rsp_totw_ff, rsp_totw_in;
   logic [rrwt_pkg::TotalW-1:0]   rsp_tott_ff, rsp_tott_in;

   logic                          accept;
   logic                          batch_end;
   logic                          slot_free;
   logic                          rsp_load;
   logic                          b_wr_en;
   logic [rrwt_pkg::AddrW-1:0]    b_rd_addr;
   logic [rrwt_pkg::BurstW-1:0]   b_rd_data;
   logic                          f_wr_en;
   logic [rrwt_pkg::TimeW-1:0]    f_rd_data;
   logic                          div_start;
   rrwt_pkg::div_stat_type        div_stat;
   logic [rrwt_pkg::QuantW-1:0]   div_rem;

   logic [rrwt_pkg::CapW-1:0]     cap_base;
   logic [rrwt_pkg::CapW-1:0]     cap_sel;
   logic [rrwt_pkg::CapW-1:0]     bj_ext;
   logic [rrwt_pkg::CapW-1:0]     served;
   logic [rrwt_pkg::TimeW-1:0]    wt_row;
   logic [rrwt_pkg::TotalW-1:0]   totw_base;
   logic [rrwt_pkg::TotalW-1:0]   tott_base;

   logic                          in_div_wait;
   logic                          cap_a_ok;

   rrwt_ram #(
      .Width (rrwt_pkg::BurstW),
      .Depth (rrwt_pkg::MaxProcs)
   ) u_burst_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (req_tdata),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   rrwt_ram #(
      .Width (rrwt_pkg::TimeW),
      .Depth (rrwt_pkg::MaxProcs)
   ) u_finish_ram (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (idx_ff),
      .wr_data (t_ff),
      .rd_addr (idx_ff),
      .rd_data (f_rd_data)
   );

   rrwt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (b_rd_data),
      .divisor   (q_eff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   assign q_eff     = (quantum_ff == '0) ? rrwt_pkg::QuantW'(1) : quantum_ff;
   assign accept    = req_tvalid && req_tready;
   assign batch_end = req_tlast || (cnt_ff == rrwt_pkg::AddrW'(rrwt_pkg::MaxProcs - 1));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrwt_pkg::ST_LOAD: begin
            if (accept && batch_end) begin
               state_in = rrwt_pkg::ST_RD_I;
            end
         end
         rrwt_pkg::ST_RD_I: begin
            state_in = rrwt_pkg::ST_CHK_I;
         end
         rrwt_pkg::ST_CHK_I: begin
            if (b_rd_data == '0) begin
               state_in = rrwt_pkg::ST_WR_F;
            end else begin
               state_in = rrwt_pkg::ST_DIV_WAIT;
            end
         end
         rrwt_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = rrwt_pkg::ST_CAP;
            end
         end
         rrwt_pkg::ST_CAP: begin
            state_in = rrwt_pkg::ST_RD_J;
         end
         rrwt_pkg::ST_RD_J: begin
            state_in = rrwt_pkg::ST_ACC_J;
         end
         rrwt_pkg::ST_ACC_J: begin
            if (jdx_ff == last_idx_ff) begin
               state_in = rrwt_pkg::ST_WR_F;
            end else begin
               state_in = rrwt_pkg::ST_RD_J;
            end
         end
         rrwt_pkg::ST_WR_F: begin
            if (idx_ff == last_idx_ff) begin
               state_in = rrwt_pkg::ST_RD_E;
            end else begin
               state_in = rrwt_pkg::ST_RD_I;
            end
         end
         rrwt_pkg::ST_RD_E: begin
            state_in = rrwt_pkg::ST_LD_E;
         end
         rrwt_pkg::ST_LD_E: begin
            if (slot_free) begin
               if (idx_ff == last_idx_ff) begin
                  state_in = rrwt_pkg::ST_LOAD;
               end else begin
                  state_in = rrwt_pkg::ST_RD_E;
               end
            end
         end
         default: begin
            state_in = rrwt_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      b_wr_en    = 1'b0;
      b_rd_addr  = idx_ff;
      f_wr_en    = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         rrwt_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            b_wr_en    = req_tvalid;
         end
         rrwt_pkg::ST_CHK_I: begin
            div_start = (b_rd_data != '0);
         end
         rrwt_pkg::ST_RD_J: begin
            b_rd_addr = jdx_ff;
         end
         rrwt_pkg::ST_WR_F: begin
            f_wr_en = 1'b1;
         end
         rrwt_pkg::ST_LD_E: begin
            rsp_load = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cap_base  = {1'b0, bi_ff} - {1'b0, div_rem};
      cap_sel   = (jdx_ff < idx_ff) ? cap_a_ff : cap_b_ff;
      bj_ext    = {1'b0, b_rd_data};
      served    = (bj_ext < cap_sel) ? bj_ext : cap_sel;
      wt_row    = f_rd_data - rrwt_pkg::TimeW'(b_rd_data);
      totw_base = (idx_ff == '0) ? '0 : rsp_totw_ff;
      tott_base = (idx_ff == '0) ? '0 : rsp_tott_ff;

      quantum_in  = csr_wr_en ? csr_wr_data : quantum_ff;
      cnt_in      = cnt_ff;
      last_idx_in = last_idx_ff;
      if (accept) begin
         cnt_in = batch_end ? '0 : cnt_ff + 1'b1;
         if (batch_end) begin
            last_idx_in = cnt_ff;
         end
      end

      idx_in   = idx_ff;
      jdx_in   = jdx_ff;
      bi_in    = bi_ff;
      t_in     = t_ff;
      cap_a_in = cap_a_ff;
      cap_b_in = cap_b_ff;
      case (state_ff)
         rrwt_pkg::ST_LOAD: begin
            idx_in = '0;
         end
         rrwt_pkg::ST_CHK_I: begin
            bi_in  = b_rd_data;
            t_in   = rrwt_pkg::TimeW'(b_rd_data);
            jdx_in = '0;
         end
         rrwt_pkg::ST_CAP: begin
            cap_a_in = cap_base + ((div_rem != '0) ? rrwt_pkg::CapW'(q_eff) : '0);
            cap_b_in = cap_base - ((div_rem == '0) ? rrwt_pkg::CapW'(q_eff) : '0);
         end
         rrwt_pkg::ST_ACC_J: begin
            jdx_in = jdx_ff + 1'b1;
            if (jdx_ff != idx_ff) begin
               t_in = t_ff + rrwt_pkg::TimeW'(served);
            end
         end
         rrwt_pkg::ST_WR_F: begin
            idx_in = (idx_ff == last_idx_ff) ? '0 : idx_ff + 1'b1;
         end
         rrwt_pkg::ST_LD_E: begin
            if (slot_free) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase

      rsp_index_in = rsp_index_ff;
      rsp_wt_in    = rsp_wt_ff;
      rsp_tat_in   = rsp_tat_ff;
      rsp_totw_in  = rsp_totw_ff;
      rsp_tott_in  = rsp_tott_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = rrwt_pkg::IndexW'(idx_ff);
         rsp_wt_in    = wt_row;
         rsp_tat_in   = f_rd_data;
         rsp_totw_in  = totw_base + rrwt_pkg::TotalW'(wt_row);
         rsp_tott_in  = tott_base + rrwt_pkg::TotalW'(f_rd_data);
         rsp_last_in  = (idx_ff == last_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrwt_pkg::ST_LOAD;
         quantum_ff   <= rrwt_pkg::QuantumReset;
         cnt_ff       <= '0;
         last_idx_ff  <= '0;
         idx_ff       <= '0;
         jdx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quantum_ff   <= quantum_in;
         cnt_ff       <= cnt_in;
         last_idx_ff  <= last_idx_in;
         idx_ff       <= idx_in;
         jdx_ff       <= jdx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bi_ff        <= bi_in;
      t_ff         <= t_in;
      cap_a_ff     <= cap_a_in;
      cap_b_ff     <= cap_b_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_wt_ff    <= rsp_wt_in;
      rsp_tat_ff   <= rsp_tat_in;
      rsp_totw_ff  <= rsp_totw_in;
      rsp_tott_ff  <= rsp_tott_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(rrwt_pkg::RspDataW - rrwt_pkg::RspFieldsW){1'b0}},
                        rsp_tott_ff, rsp_totw_ff, rsp_tat_ff, rsp_wt_ff, rsp_index_ff};

   assign in_div_wait = (state_ff == rrwt_pkg::ST_DIV_WAIT);
   assign cap_a_ok    = (cap_a_ff >= rrwt_pkg::CapW'(bi_ff))
                        && ((cap_a_ff - rrwt_pkg::CapW'(bi_ff)) < rrwt_pkg::CapW'(q_eff));

   `RRWT_ASSERT_SAME(a_div_done_waited, clock, reset, div_stat.done, in_div_wait)
   `RRWT_ASSERT_SAME(a_div_busy, clock, reset, in_div_wait && !div_stat.done, div_stat.busy)
   `RRWT_ASSERT_NEXT(a_cap_bounds, clock, reset, state_ff == rrwt_pkg::ST_CAP, cap_a_ok)
   `RRWT_ASSERT_SAME(a_finish_covers_burst, clock, reset, f_wr_en, t_ff >= rrwt_pkg::TimeW'(bi_ff))

endmodule

@@ hdl/rrwt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module rrwt_ram #(
   parameter int Width = 16,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rrwt_div.sv @@
// Restoring divider that yields the remainder of a burst time by the quantum, one bit a cycle.
module rrwt_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rrwt_pkg::BurstW-1:0]  dividend,
   input  logic [rrwt_pkg::QuantW-1:0]  divisor,
   output rrwt_pkg::div_stat_type       stat,
   output logic [rrwt_pkg::QuantW-1:0]  remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rrwt_pkg::DivCntW-1:0]  cnt_ff, cnt_in;
   logic [rrwt_pkg::QuantW-1:0]   rem_ff, rem_in;
   logic [rrwt_pkg::BurstW-1:0]   dvd_ff, dvd_in;
   logic [rrwt_pkg::QuantW-1:0]   dvs_ff, dvs_in;
   logic [rrwt_pkg::QuantW:0]     trial;
   logic [rrwt_pkg::QuantW:0]     diff;
   logic                          last_step;

   always_comb begin
      trial     = {rem_ff, dvd_ff[rrwt_pkg::BurstW-1]};
      diff      = trial - {1'b0, dvs_ff};
      last_step = busy_ff && (cnt_ff == rrwt_pkg::DivCntW'(rrwt_pkg::BurstW - 1));
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      done_in   = last_step;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[rrwt_pkg::QuantW-1:0];
         end else begin
            rem_in = trial[rrwt_pkg::QuantW-1:0];
         end
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule
